### hw/rtl/pvns_pkg.sv
// Shared constants, codes and types of the polygon vertex nearest search unit.
package pvns_pkg;

  // Store geometry
  localparam int MaxVertices = 64;
  localparam int AddrBits    = $clog2(MaxVertices);
  localparam int CountBits   = $clog2(MaxVertices + 1);
  localparam int CoordBits   = 16;
  localparam int WordBits    = 2 * CoordBits;
  localparam int ActionBits  = 3;
  localparam int StatusBits  = 2;

  // Action codes
  localparam logic [ActionBits-1:0] ActClear     = 3'd0;
  localparam logic [ActionBits-1:0] ActAppend    = 3'd1;
  localparam logic [ActionBits-1:0] ActInsert    = 3'd2;
  localparam logic [ActionBits-1:0] ActRemove    = 3'd3;
  localparam logic [ActionBits-1:0] ActTranslate = 3'd4;
  localparam logic [ActionBits-1:0] ActQuery     = 3'd5;

  // Status codes
  localparam logic [StatusBits-1:0] StOk       = 2'd0;
  localparam logic [StatusBits-1:0] StFull     = 2'd1;
  localparam logic [StatusBits-1:0] StBadIndex = 2'd2;
  localparam logic [StatusBits-1:0] StEmpty    = 2'd3;

  typedef logic signed [CoordBits-1:0] coord_t;

  // One vertex handed from the read port to the distance pipeline
  typedef struct packed {
    logic                valid;
    logic [AddrBits-1:0] idx;
    coord_t              x;
    coord_t              y;
  } dist_req_t;

  // One finished result beat
  typedef struct packed {
    logic [AddrBits-1:0]   nearest_index;
    logic [CountBits-1:0]  vertex_count;
    logic [StatusBits-1:0] status;
  } result_t;

endpackage

### hw/rtl/pvns_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module pvns_ram #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hw/rtl/pvns_dist.sv
// Squared distance pipeline with running minimum for the nearest query.
module pvns_dist (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pvns_pkg::dist_req_t                 req_i,
  input  pvns_pkg::coord_t                    px_i,
  input  pvns_pkg::coord_t                    py_i,
  output logic                                busy_o,
  output logic [pvns_pkg::AddrBits-1:0]       best_idx_o
);

  localparam int CW = pvns_pkg::CoordBits;
  localparam int AW = pvns_pkg::AddrBits;

  logic signed [CW:0]  diff_x, diff_y;
  logic [CW:0]         mag_x, mag_y;
  logic                s1_v_q, s2_v_q;
  logic [AW-1:0]       s1_idx_q, s2_idx_q;
  logic [CW-1:0]       s1_ax_q, s1_ay_q;
  logic [2*CW-1:0]     s2_sx_q, s2_sy_q;
  logic [2*CW:0]       sum;
  logic [2*CW:0]       best_dist_q;
  logic [AW-1:0]       best_idx_q;

  // Absolute coordinate differences
  always_comb begin
    diff_x = $signed({req_i.x[CW-1], req_i.x}) - $signed({px_i[CW-1], px_i});
    diff_y = $signed({req_i.y[CW-1], req_i.y}) - $signed({py_i[CW-1], py_i});
    mag_x  = diff_x[CW] ? (~diff_x + 1'b1) : diff_x;
    mag_y  = diff_y[CW] ? (~diff_y + 1'b1) : diff_y;
  end

  // Valid flags of the two pipeline stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= req_i.valid;
      s2_v_q <= s1_v_q;
    end
  end

  // Stage 1: magnitudes; stage 2: squares
  always_ff @(posedge clk_i) begin
    s1_idx_q <= req_i.idx;
    s1_ax_q  <= mag_x[CW-1:0];
    s1_ay_q  <= mag_y[CW-1:0];
    s2_idx_q <= s1_idx_q;
    s2_sx_q  <= s1_ax_q * s1_ax_q;
    s2_sy_q  <= s1_ay_q * s1_ay_q;
  end

  assign sum = {1'b0, s2_sx_q} + {1'b0, s2_sy_q};

  // Keep the strictly smaller distance; vertex zero restarts the search
  always_ff @(posedge clk_i) begin
    if (s2_v_q && ((s2_idx_q == '0) || (sum < best_dist_q))) begin
      best_dist_q <= sum;
      best_idx_q  <= s2_idx_q;
    end
  end

  assign busy_o     = s1_v_q | s2_v_q;
  assign best_idx_o = best_idx_q;

endmodule

### hw/rtl/pvns_seq.sv
// Operation sequencer: decode, store walk, read-modify-write and result build.
module pvns_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pvns_pkg::ActionBits-1:0]      action_i,
  input  logic [pvns_pkg::CountBits-1:0]       index_i,
  input  pvns_pkg::coord_t                     point_x_i,
  input  pvns_pkg::coord_t                     point_y_i,
  input  pvns_pkg::coord_t                     to_x_i,
  input  pvns_pkg::coord_t                     to_y_i,
  output logic                                 ram_we_o,
  output logic [pvns_pkg::AddrBits-1:0]        ram_waddr_o,
  output logic [pvns_pkg::WordBits-1:0]        ram_wdata_o,
  output logic                                 ram_re_o,
  output logic [pvns_pkg::AddrBits-1:0]        ram_raddr_o,
  input  logic [pvns_pkg::WordBits-1:0]        ram_rdata_i,
  output pvns_pkg::dist_req_t                  dist_req_o,
  output pvns_pkg::coord_t                     px_o,
  output pvns_pkg::coord_t                     py_o,
  input  logic                                 dist_busy_i,
  input  logic [pvns_pkg::AddrBits-1:0]        best_idx_i,
  output logic                                 res_valid_o,
  input  logic                                 res_take_i,
  output pvns_pkg::result_t                    res_o
);

  localparam int CW = pvns_pkg::CoordBits;
  localparam int NW = pvns_pkg::CountBits;
  localparam int AW = pvns_pkg::AddrBits;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SRun    = 3'd1;
  localparam logic [2:0] SDrain  = 3'd2;
  localparam logic [2:0] SWrite  = 3'd3;
  localparam logic [2:0] SFinish = 3'd4;

  localparam logic [NW-1:0] FullCount = NW'(pvns_pkg::MaxVertices);

  function automatic pvns_pkg::coord_t sat_add(input pvns_pkg::coord_t v,
                                               input logic signed [CW:0] d);
    logic [CW+1:0]    s;
    pvns_pkg::coord_t r;
    s = {{2{v[CW-1]}}, v} + {d[CW], d};
    if ((s[CW+1:CW-1] == '0) || (s[CW+1:CW-1] == '1)) begin
      r = s[CW-1:0];
    end else if (!s[CW+1]) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = {1'b1, {(CW-1){1'b0}}};
    end
    return r;
  endfunction

  logic [2:0]                          state_q, state_d;
  logic [pvns_pkg::ActionBits-1:0]     op_q;
  logic [pvns_pkg::StatusBits-1:0]     status_q, dec_status;
  logic [NW-1:0]                       count_q, dec_count, cnt_m1;
  logic [NW-1:0]                       ptr_q, last_q, widx_q, dec_ptr, dec_last, dec_widx;
  logic [2:0]                          dec_state;
  pvns_pkg::coord_t                    px_q, py_q;
  logic signed [CW:0]                  dx_q, dy_q;
  logic                                rv_q;
  logic [AW-1:0]                       raddr_q;
  logic                                in_acc, run_last, pipe_we;
  pvns_pkg::coord_t                    rd_x, rd_y;

  assign in_acc   = in_valid_i && (state_q == SIdle);
  assign cnt_m1   = count_q - 1'b1;
  assign run_last = (ptr_q == last_q);
  assign rd_x     = ram_rdata_i[2*CW-1:CW];
  assign rd_y     = ram_rdata_i[CW-1:0];

  // Decode the incoming beat against the current count
  always_comb begin
    dec_status = pvns_pkg::StOk;
    dec_count  = count_q;
    dec_state  = SFinish;
    dec_ptr    = '0;
    dec_last   = cnt_m1;
    dec_widx   = count_q;
    unique case (action_i)
      pvns_pkg::ActClear: begin
        dec_count = '0;
      end
      pvns_pkg::ActAppend: begin
        if (count_q >= FullCount) begin
          dec_status = pvns_pkg::StFull;
        end else begin
          dec_count = count_q + 1'b1;
          dec_state = SWrite;
        end
      end
      pvns_pkg::ActInsert: begin
        dec_widx = index_i;
        dec_ptr  = cnt_m1;
        dec_last = index_i;
        if (count_q >= FullCount) begin
          dec_status = pvns_pkg::StFull;
        end else if (index_i > count_q) begin
          dec_status = pvns_pkg::StBadIndex;
        end else begin
          dec_count = count_q + 1'b1;
          dec_state = (index_i == count_q) ? SWrite : SRun;
        end
      end
      pvns_pkg::ActRemove: begin
        dec_ptr = index_i + 1'b1;
        if (index_i >= count_q) begin
          dec_status = pvns_pkg::StBadIndex;
        end else begin
          dec_count = cnt_m1;
          dec_state = (index_i == cnt_m1) ? SFinish : SRun;
        end
      end
      pvns_pkg::ActTranslate: begin
        dec_state = (count_q == '0) ? SFinish : SRun;
      end
      pvns_pkg::ActQuery: begin
        if (count_q == '0) begin
          dec_status = pvns_pkg::StEmpty;
        end else begin
          dec_state = SRun;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          state_d = dec_state;
        end
      end
      SRun: begin
        if (run_last) begin
          state_d = SDrain;
        end
      end
      SDrain: begin
        if (!rv_q && !dist_busy_i) begin
          state_d = (op_q == pvns_pkg::ActInsert) ? SWrite : SFinish;
        end
      end
      SWrite: begin
        state_d = SFinish;
      end
      SFinish: begin
        if (res_take_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= (state_q == SRun);
      if (in_acc) begin
        count_q <= dec_count;
      end
    end
  end

  // Operation context and walk pointer
  always_ff @(posedge clk_i) begin
    raddr_q <= ptr_q[AW-1:0];
    if (in_acc) begin
      op_q     <= action_i;
      status_q <= dec_status;
      ptr_q    <= dec_ptr;
      last_q   <= dec_last;
      widx_q   <= dec_widx;
      px_q     <= point_x_i;
      py_q     <= point_y_i;
      dx_q     <= $signed({to_x_i[CW-1], to_x_i}) - $signed({point_x_i[CW-1], point_x_i});
      dy_q     <= $signed({to_y_i[CW-1], to_y_i}) - $signed({point_y_i[CW-1], point_y_i});
    end else if ((state_q == SRun) && !run_last) begin
      ptr_q <= (op_q == pvns_pkg::ActInsert) ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
    end
  end

  // Issue one read per cycle of the walk
  assign ram_re_o    = (state_q == SRun);
  assign ram_raddr_o = ptr_q[AW-1:0];

  // Write back the word read in the previous cycle, or place the new vertex
  always_comb begin
    pipe_we     = 1'b0;
    ram_waddr_o = raddr_q;
    ram_wdata_o = ram_rdata_i;
    case (op_q)
      pvns_pkg::ActInsert: begin
        pipe_we     = rv_q;
        ram_waddr_o = raddr_q + 1'b1;
      end
      pvns_pkg::ActRemove: begin
        pipe_we     = rv_q;
        ram_waddr_o = raddr_q - 1'b1;
      end
      pvns_pkg::ActTranslate: begin
        pipe_we     = rv_q;
        ram_wdata_o = {sat_add(rd_x, dx_q), sat_add(rd_y, dy_q)};
      end
      default: begin
      end
    endcase
    if (state_q == SWrite) begin
      ram_waddr_o = widx_q[AW-1:0];
      ram_wdata_o = {px_q, py_q};
    end
  end

  assign ram_we_o = pipe_we || (state_q == SWrite);

  // Feed vertices of a query into the distance pipeline
  assign dist_req_o.valid = rv_q && (op_q == pvns_pkg::ActQuery);
  assign dist_req_o.idx   = raddr_q;
  assign dist_req_o.x     = rd_x;
  assign dist_req_o.y     = rd_y;
  assign px_o             = px_q;
  assign py_o             = py_q;

  // Result beat
  assign in_stall_o    = (state_q != SIdle);
  assign res_valid_o   = (state_q == SFinish);
  assign res_o.status  = status_q;
  assign res_o.vertex_count = count_q;
  assign res_o.nearest_index =
    ((op_q == pvns_pkg::ActQuery) && (status_q == pvns_pkg::StOk)) ? best_idx_i : '0;

endmodule

### hw/rtl/polygon_vertex_nearest_search_unit.sv
// Top level: ordered polygon vertex store with nearest-vertex query.
// Holds up to 64 vertices in one 64 x 32-bit synchronous RAM (x and y of a
// vertex side by side) and serves one operation per input beat. Clear, a
// rejected operation, a translate of an empty store and unused actions go
// straight to the result beat; append first writes the new vertex. Insert,
// remove and translate walk the stored vertices that move, one RAM read per
// cycle with the write-back of each word in the cycle after its read, and
// insert then writes the new vertex; a remove of the last vertex goes
// straight to the result and an insert at the end only writes the vertex.
// A query walks all n vertices through the distance pipeline (magnitude and
// square stages, then the running minimum).
// The RAM read port is the limit: one vertex per cycle. The next beat is
// accepted once the result has moved into the output register, even while
// that result is still stalled. The store needs no clearing after reset.
module polygon_vertex_nearest_search_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pvns_pkg::ActionBits-1:0]   action_i,
  input  logic [pvns_pkg::CountBits-1:0]    index_i,
  input  logic signed [pvns_pkg::CoordBits-1:0] point_x_i,
  input  logic signed [pvns_pkg::CoordBits-1:0] point_y_i,
  input  logic signed [pvns_pkg::CoordBits-1:0] to_x_i,
  input  logic signed [pvns_pkg::CoordBits-1:0] to_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pvns_pkg::AddrBits-1:0]     nearest_index_o,
  output logic [pvns_pkg::CountBits-1:0]    vertex_count_o,
  output logic [pvns_pkg::StatusBits-1:0]   status_o
);

  logic                              ram_we, ram_re;
  logic [pvns_pkg::AddrBits-1:0]     ram_waddr, ram_raddr;
  logic [pvns_pkg::WordBits-1:0]     ram_wdata, ram_rdata;
  pvns_pkg::dist_req_t               dist_req;
  pvns_pkg::coord_t                  px, py;
  logic                              dist_busy;
  logic [pvns_pkg::AddrBits-1:0]     best_idx;
  logic                              res_valid, res_take;
  pvns_pkg::result_t                 res;
  logic                              out_valid_q;
  pvns_pkg::result_t                 out_q;

  pvns_ram #(
    .Depth(pvns_pkg::MaxVertices),
    .Width(pvns_pkg::WordBits)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pvns_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .index_i    (index_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .to_x_i     (to_x_i),
    .to_y_i     (to_y_i),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .dist_req_o (dist_req),
    .px_o       (px),
    .py_o       (py),
    .dist_busy_i(dist_busy),
    .best_idx_i (best_idx),
    .res_valid_o(res_valid),
    .res_take_i (res_take),
    .res_o      (res)
  );

  pvns_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (dist_req),
    .px_i      (px),
    .py_i      (py),
    .busy_o    (dist_busy),
    .best_idx_o(best_idx)
  );

  // Output register takes a result whenever it is empty or being drained
  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result payload while stalled
  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = out_q.nearest_index;
  assign vertex_count_o  = out_q.vertex_count;
  assign status_o        = out_q.status;

endmodule
